// ===== hdl/midpoint_ellipse_rasterizer_defines.svh =====
// Assertion macros shared by the ellipse rasterizer modules.
`ifndef MIDPOINT_ELLIPSE_RASTERIZER_DEFINES_SVH
`define MIDPOINT_ELLIPSE_RASTERIZER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define MER_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define MER_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/mer_pkg.sv =====
// Shared widths, types and codes of the midpoint ellipse rasterizer.
package mer_pkg;

  localparam int RADIUS_BITS = 10;
  localparam int COORD_BITS  = 11;
  localparam int PIX_BITS    = COORD_BITS + 2;
  localparam int SQ_BITS     = 2 * RADIUS_BITS;
  localparam int TX2_BITS    = 2 * (COORD_BITS + 1);
  localparam int WIDE_BITS   = (SQ_BITS > TX2_BITS) ? SQ_BITS : TX2_BITS;
  localparam int MUL_W       = WIDE_BITS + 1;
  localparam int PROD_W      = 2 * MUL_W;
  localparam int SLOPE_W     = SQ_BITS + COORD_BITS + 5;
  localparam int DEC_W       = SQ_BITS + WIDE_BITS + 2;

  localparam int IN_FIELD_BITS = 2 * COORD_BITS + 2 * RADIUS_BITS;
  localparam int IN_DATA_W     = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W    = ((2 * PIX_BITS + 7) / 8) * 8;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int PH_W = 3;
  localparam logic [PH_W-1:0] PH_0 = 3'd0;
  localparam logic [PH_W-1:0] PH_1 = 3'd1;
  localparam logic [PH_W-1:0] PH_2 = 3'd2;
  localparam logic [PH_W-1:0] PH_3 = 3'd3;
  localparam logic [PH_W-1:0] PH_4 = 3'd4;

  localparam logic [1:0] PT_LAST = 2'd3;

  typedef enum logic {
    KIND_START   = 1'b0,
    KIND_ADVANCE = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t                  kind;
    logic [COORD_BITS-1:0]  center_x;
    logic [COORD_BITS-1:0]  center_y;
    logic [RADIUS_BITS-1:0] radius_x;
    logic [RADIUS_BITS-1:0] radius_y;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SETUP = 4'b0010,
    ST_ENTRY = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

endpackage

// ===== hdl/mer_mul.sv =====
// Shared signed multiplier with a registered product.
module mer_mul
  import mer_pkg::*;
(
  input  logic                     clk,
  input  logic signed [MUL_W-1:0]  mul_a,
  input  logic signed [MUL_W-1:0]  mul_b,
  output logic signed [PROD_W-1:0] mul_p
);

  logic signed [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  assign mul_p = prod_r;

endmodule

// ===== hdl/mer_front.sv =====
// Input intake: decodes the transaction kind and queues items for the sequencer.
`include "midpoint_ellipse_rasterizer_defines.svh"
module mer_front
  import mer_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,
  input  logic                 in_tuser,
  output head_t                head,
  input  logic                 item_pop
);

  item_t               q_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;
  logic                push;
  item_t               in_item;

  always_comb begin
    in_item.kind     = in_tuser ? KIND_ADVANCE : KIND_START;
    in_item.center_x = in_tdata[COORD_BITS-1:0];
    in_item.center_y = in_tdata[2*COORD_BITS-1:COORD_BITS];
    in_item.radius_x = in_tdata[2*COORD_BITS+RADIUS_BITS-1:2*COORD_BITS];
    in_item.radius_y = in_tdata[2*COORD_BITS+2*RADIUS_BITS-1:2*COORD_BITS+RADIUS_BITS];
  end

  assign in_tready  = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign push       = in_tvalid && in_tready;
  assign head.valid = (count_r != '0);
  assign head.item  = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (item_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !item_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && item_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= in_item;
    end
  end

  `MER_ASSERT_IMP(a_queue_no_overflow, clk, rst_n, 1'b1, count_r <= QCNT_W'(QUEUE_DEPTH), "input queue count beyond depth")
  `MER_ASSERT_IMP(a_pop_not_empty, clk, rst_n, item_pop, head.valid, "pop from empty input queue")

endmodule

// ===== hdl/mer_back.sv =====
// Sequencer: start setup, region-2 entry, point emission and midpoint stepping.
`include "midpoint_ellipse_rasterizer_defines.svh"
module mer_back
  import mer_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  head_t                    head,
  output logic                     item_pop,
  output logic signed [MUL_W-1:0]  mul_a,
  output logic signed [MUL_W-1:0]  mul_b,
  input  logic signed [PROD_W-1:0] mul_p,
  input  logic                     out_tready,
  output logic                     out_tvalid,
  output logic [PIX_BITS-1:0]      out_pixel_x,
  output logic [PIX_BITS-1:0]      out_pixel_y,
  output logic                     out_group_last,
  output logic                     out_finished
);

  state_t                    state_r, state_nxt;
  logic [PH_W-1:0]           ph_r, ph_nxt;
  logic [1:0]                k_r, k_nxt;
  logic                      active_r, active_nxt;
  logic                      r2_r, r2_nxt;
  logic                      out_tvalid_r, out_tvalid_nxt;

  logic [COORD_BITS-1:0]     cx_r, cx_nxt, cy_r, cy_nxt;
  logic [RADIUS_BITS-1:0]    rx_r, rx_nxt, ry_r, ry_nxt;
  logic [SQ_BITS-1:0]        rx2_r, rx2_nxt, ry2_r, ry2_nxt;
  logic [2*SQ_BITS-1:0]      rxry2_r, rxry2_nxt;
  logic signed [DEC_W-1:0]   acc_r, acc_nxt;
  logic [COORD_BITS-1:0]     x_r, x_nxt, y_r, y_nxt;
  logic signed [SLOPE_W-1:0] sx_r, sx_nxt, sy_r, sy_nxt;
  logic signed [DEC_W-1:0]   dec_r, dec_nxt;
  logic [PIX_BITS-1:0]       px_r, px_nxt, py_r, py_nxt;
  logic                      last_r, last_nxt, fin_r, fin_nxt;

  logic                      out_free;
  logic                      fin_w;
  logic                      emit_last;
  logic signed [COORD_BITS:0] ty_w;
  logic signed [SLOPE_W-1:0] sx_inc, sy_dec;
  logic signed [DEC_W-1:0]   sx_inc_d, sy_dec_d, rx2_d, ry2_d, rxry2_d, p_dec;
  logic [PIX_BITS-1:0]       cx_p, cy_p, x_p, y_p;

  assign out_free  = !out_tvalid_r || out_tready;
  assign fin_w     = r2_r && (y_r == '0);
  assign emit_last = (state_r == ST_EMIT) && out_free && (k_r == PT_LAST);
  assign ty_w      = {1'b0, y_r} - {{COORD_BITS{1'b0}}, 1'b1};

  assign sx_inc   = sx_r + {{(SLOPE_W-SQ_BITS-1){1'b0}}, ry2_r, 1'b0};
  assign sy_dec   = sy_r - {{(SLOPE_W-SQ_BITS-1){1'b0}}, rx2_r, 1'b0};
  assign sx_inc_d = {{(DEC_W-SLOPE_W){sx_inc[SLOPE_W-1]}}, sx_inc};
  assign sy_dec_d = {{(DEC_W-SLOPE_W){sy_dec[SLOPE_W-1]}}, sy_dec};
  assign rx2_d    = {{(DEC_W-SQ_BITS){1'b0}}, rx2_r};
  assign ry2_d    = {{(DEC_W-SQ_BITS){1'b0}}, ry2_r};
  assign rxry2_d  = {{(DEC_W-2*SQ_BITS){1'b0}}, rxry2_r};
  assign p_dec    = mul_p[DEC_W-1:0];

  assign cx_p = {{(PIX_BITS-COORD_BITS){1'b0}}, cx_r};
  assign cy_p = {{(PIX_BITS-COORD_BITS){1'b0}}, cy_r};
  assign x_p  = {{(PIX_BITS-COORD_BITS){1'b0}}, x_r};
  assign y_p  = {{(PIX_BITS-COORD_BITS){1'b0}}, y_r};

  always_comb begin
    state_nxt      = state_r;
    ph_nxt         = ph_r;
    k_nxt          = k_r;
    active_nxt     = active_r;
    r2_nxt         = r2_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    cx_nxt         = cx_r;
    cy_nxt         = cy_r;
    rx_nxt         = rx_r;
    ry_nxt         = ry_r;
    rx2_nxt        = rx2_r;
    ry2_nxt        = ry2_r;
    rxry2_nxt      = rxry2_r;
    acc_nxt        = acc_r;
    x_nxt          = x_r;
    y_nxt          = y_r;
    sx_nxt         = sx_r;
    sy_nxt         = sy_r;
    dec_nxt        = dec_r;
    px_nxt         = px_r;
    py_nxt         = py_r;
    last_nxt       = last_r;
    fin_nxt        = fin_r;
    item_pop       = 1'b0;
    mul_a          = '0;
    mul_b          = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (head.valid) begin
          item_pop = 1'b1;
          if (head.item.kind == KIND_START) begin
            cx_nxt    = head.item.center_x;
            cy_nxt    = head.item.center_y;
            rx_nxt    = head.item.radius_x;
            ry_nxt    = head.item.radius_y;
            ph_nxt    = PH_0;
            state_nxt = ST_SETUP;
          end else if (active_r) begin
            if (!r2_r && !(sx_r < sy_r)) begin
              r2_nxt    = 1'b1;
              ph_nxt    = PH_0;
              state_nxt = ST_ENTRY;
            end else begin
              k_nxt     = '0;
              state_nxt = ST_EMIT;
            end
          end
        end
      end
      ST_SETUP: begin
        // rx^2, ry^2, rx^2*ry, rx^2*ry^2 through the shared multiplier
        ph_nxt = ph_r + 1'b1;
        unique case (ph_r)
          PH_0: begin
            mul_a = {{(MUL_W-RADIUS_BITS){1'b0}}, rx_r};
            mul_b = {{(MUL_W-RADIUS_BITS){1'b0}}, rx_r};
          end
          PH_1: begin
            rx2_nxt = mul_p[SQ_BITS-1:0];
            mul_a   = {{(MUL_W-RADIUS_BITS){1'b0}}, ry_r};
            mul_b   = {{(MUL_W-RADIUS_BITS){1'b0}}, ry_r};
          end
          PH_2: begin
            ry2_nxt = mul_p[SQ_BITS-1:0];
            mul_a   = {{(MUL_W-SQ_BITS){1'b0}}, rx2_r};
            mul_b   = {{(MUL_W-RADIUS_BITS){1'b0}}, ry_r};
          end
          PH_3: begin
            acc_nxt = p_dec;
            mul_a   = {{(MUL_W-SQ_BITS){1'b0}}, rx2_r};
            mul_b   = {{(MUL_W-SQ_BITS){1'b0}}, ry2_r};
          end
          PH_4: begin
            rxry2_nxt  = mul_p[2*SQ_BITS-1:0];
            x_nxt      = '0;
            y_nxt      = {{(COORD_BITS-RADIUS_BITS){1'b0}}, ry_r};
            sx_nxt     = '0;
            sy_nxt     = {acc_r[SLOPE_W-2:0], 1'b0};
            dec_nxt    = (ry2_d <<< 2) - (acc_r <<< 2) + rx2_d;
            r2_nxt     = 1'b0;
            active_nxt = 1'b1;
            state_nxt  = ST_IDLE;
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_ENTRY: begin
        // ry^2*(2x+1)^2 + 4*rx^2*(y-1)^2 - 4*rx^2*ry^2
        ph_nxt = ph_r + 1'b1;
        unique case (ph_r)
          PH_0: begin
            mul_a = {{(MUL_W-COORD_BITS-1){1'b0}}, x_r, 1'b1};
            mul_b = {{(MUL_W-COORD_BITS-1){1'b0}}, x_r, 1'b1};
          end
          PH_1: begin
            mul_a = mul_p[MUL_W-1:0];
            mul_b = {{(MUL_W-SQ_BITS){1'b0}}, ry2_r};
          end
          PH_2: begin
            acc_nxt = p_dec;
            mul_a   = {{(MUL_W-COORD_BITS-1){ty_w[COORD_BITS]}}, ty_w};
            mul_b   = {{(MUL_W-COORD_BITS-1){ty_w[COORD_BITS]}}, ty_w};
          end
          PH_3: begin
            mul_a = mul_p[MUL_W-1:0];
            mul_b = {{(MUL_W-SQ_BITS){1'b0}}, rx2_r};
          end
          PH_4: begin
            dec_nxt   = acc_r + (p_dec <<< 2) - (rxry2_d <<< 2);
            k_nxt     = '0;
            state_nxt = ST_EMIT;
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_EMIT: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          px_nxt   = k_r[0] ? (cx_p - x_p) : (cx_p + x_p);
          py_nxt   = k_r[1] ? (cy_p - y_p) : (cy_p + y_p);
          last_nxt = (k_r == PT_LAST);
          fin_nxt  = (k_r == PT_LAST) && fin_w;
          k_nxt    = k_r + 1'b1;
          if (k_r == PT_LAST) begin
            // midpoint step taken alongside the last point of the group
            if (!r2_r) begin
              x_nxt  = x_r + 1'b1;
              sx_nxt = sx_inc;
              if (dec_r < 0) begin
                dec_nxt = dec_r + (sx_inc_d <<< 2) + (ry2_d <<< 2);
              end else begin
                y_nxt   = y_r - 1'b1;
                sy_nxt  = sy_dec;
                dec_nxt = dec_r + ((sx_inc_d - sy_dec_d + ry2_d) <<< 2);
              end
            end else begin
              y_nxt  = y_r - 1'b1;
              sy_nxt = sy_dec;
              if (dec_r > 0) begin
                dec_nxt = dec_r + ((rx2_d - sy_dec_d) <<< 2);
              end else begin
                x_nxt   = x_r + 1'b1;
                sx_nxt  = sx_inc;
                dec_nxt = dec_r + ((sx_inc_d - sy_dec_d + rx2_d) <<< 2);
              end
            end
            if (fin_w) begin
              active_nxt = 1'b0;
            end
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      ph_r         <= PH_0;
      k_r          <= '0;
      active_r     <= 1'b0;
      r2_r         <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      ph_r         <= ph_nxt;
      k_r          <= k_nxt;
      active_r     <= active_nxt;
      r2_r         <= r2_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cx_r    <= cx_nxt;
    cy_r    <= cy_nxt;
    rx_r    <= rx_nxt;
    ry_r    <= ry_nxt;
    rx2_r   <= rx2_nxt;
    ry2_r   <= ry2_nxt;
    rxry2_r <= rxry2_nxt;
    acc_r   <= acc_nxt;
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    sx_r    <= sx_nxt;
    sy_r    <= sy_nxt;
    dec_r   <= dec_nxt;
    px_r    <= px_nxt;
    py_r    <= py_nxt;
    last_r  <= last_nxt;
    fin_r   <= fin_nxt;
  end

  assign out_tvalid     = out_tvalid_r;
  assign out_pixel_x    = px_r;
  assign out_pixel_y    = py_r;
  assign out_group_last = last_r;
  assign out_finished   = fin_r;

  `MER_ASSERT_IMP(a_fin_on_last, clk, rst_n, out_tvalid_r && fin_r, last_r, "finished flag off the group's last point")
  `MER_ASSERT_NXT(a_fin_goes_idle, clk, rst_n, emit_last && fin_w, !active_r && (state_r == ST_IDLE), "ellipse still active after its last point")
  `MER_ASSERT_IMP(a_emit_needs_active, clk, rst_n, state_r == ST_EMIT, active_r, "emitting points with no ellipse loaded")

endmodule

// ===== hdl/midpoint_ellipse_rasterizer.sv =====
// Midpoint ellipse rasterizer top level: input queue, sequencer and shared multiplier.
//
// A start transaction (in_tuser = 0) loads center and semi-axes and gives no output;
// each advance transaction (in_tuser = 1) sends the four symmetric points of the
// current position, one per output transaction in the order (+x,+y), (-x,+y),
// (+x,-y), (-x,-y), then takes one midpoint step. out_tlast marks the fourth point
// of a group and out_tuser marks the very last point of the ellipse, after which
// advances are dropped until the next start. Inputs go into a two-entry queue, so
// up to two transactions are taken while the sequencer works. An advance is dispatched
// from the idle state and then sends its four points through the single output
// register; the advance that enters region 2 first passes through the entry state, and
// a start passes through the setup state, each of which uses the one shared multiplier
// (four registered products).
module midpoint_ellipse_rasterizer
  import mer_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,  // center_x, center_y, radius_x, radius_y, zero pad
  input  logic                  in_tuser,  // mode
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata, // pixel_x, pixel_y, zero pad
  output logic                  out_tlast, // group_last
  output logic                  out_tuser  // finished
);

  head_t                    head;
  logic                     item_pop;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic [PIX_BITS-1:0]      pixel_x, pixel_y;

  mer_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .head      (head),
    .item_pop  (item_pop)
  );

  mer_mul u_mul (
    .clk   (clk),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .mul_p (mul_p)
  );

  mer_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .item_pop       (item_pop),
    .mul_a          (mul_a),
    .mul_b          (mul_b),
    .mul_p          (mul_p),
    .out_tready     (out_tready),
    .out_tvalid     (out_tvalid),
    .out_pixel_x    (pixel_x),
    .out_pixel_y    (pixel_y),
    .out_group_last (out_tlast),
    .out_finished   (out_tuser)
  );

  assign out_tdata = {{(OUT_DATA_W-2*PIX_BITS){1'b0}}, pixel_y, pixel_x};

endmodule
